// File: hw/rtl/slmm_pkg.sv
package slmm_pkg;

    localparam logic [1:0] KIND_INSERT     = 2'd0;
    localparam logic [1:0] KIND_REMOVE_MIN = 2'd1;
    localparam logic [1:0] KIND_REMOVE_MAX = 2'd2;

    localparam logic [1:0] STATUS_DONE  = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

endpackage

// File: hw/rtl/slmm_ram.sv
module slmm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: hw/rtl/sorted_list_min_max_remove_top.sv
// Channel   | Ports                                         | Direction
// request   | s_valid s_ready s_kind s_value                | in
// result    | m_valid m_ready m_status m_removed_value      | out
//           | m_entry_count                                 |
//
// One request at a time; s_ready is high only while no request is in work.
// Insert: after the accept, walk down from the top, shifting each entry >= value
// up one slot through the single RAM port pair, then write the value, then the
// result. Insert into an empty list writes in the accept cycle, then the result.
// Remove smallest: capture entry 0, then move each later entry down one slot.
// Remove largest: capture top entry. Empty/full/unused kinds go right to result.
// Synchronous active-low reset clears the entry count; RAM contents are not
// cleared. A stalled result holds until m_ready; no request is taken meanwhile.
module sorted_list_min_max_remove_top #(
    parameter int DEPTH      = 16,
    parameter int VALUE_BITS = 32
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [1:0]                          s_kind,
    input  logic signed [VALUE_BITS-1:0]        s_value,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [1:0]                          m_status,
    output logic signed [VALUE_BITS-1:0]        m_removed_value,
    output logic [$clog2(DEPTH+1)-1:0]          m_entry_count
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INS,
        ST_INS_LAST,
        ST_MIN_CAP,
        ST_MIN_SH,
        ST_MAX_CAP,
        ST_OUT
    } state_t;

    state_t                       state_reg;
    logic [CW-1:0]                cnt_reg;
    logic [AW-1:0]                idx_reg;
    logic signed [VALUE_BITS-1:0] val_reg;
    logic [1:0]                   status_reg;
    logic signed [VALUE_BITS-1:0] removed_reg;

    logic                         ram_we;
    logic [AW-1:0]                ram_waddr;
    logic [VALUE_BITS-1:0]        ram_wdata;
    logic [AW-1:0]                ram_raddr;
    logic [VALUE_BITS-1:0]        ram_rdata;

    logic [CW-1:0]                cnt_dec;
    logic [AW-1:0]                cnt_m1;
    logic                         entry_ge;
    logic                         accept;

    assign cnt_dec  = cnt_reg - CW'(1);
    assign cnt_m1   = cnt_dec[AW-1:0];
    assign entry_ge = $signed(ram_rdata) >= val_reg;
    assign accept   = s_valid && s_ready;

    assign s_ready         = (state_reg == ST_IDLE);
    assign m_valid         = (state_reg == ST_OUT);
    assign m_status        = status_reg;
    assign m_removed_value = removed_reg;
    assign m_entry_count   = cnt_reg;

    slmm_ram #(
        .WIDTH(VALUE_BITS),
        .DEPTH(DEPTH)
    ) u_ram (
        .clk  (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = idx_reg;
        ram_wdata = val_reg;
        ram_raddr = idx_reg;
        case (state_reg)
            ST_IDLE: begin
                // prefetch the entry the request will look at first
                ram_raddr = (s_kind == slmm_pkg::KIND_REMOVE_MIN) ? '0 : cnt_m1;
                if (s_valid && s_kind == slmm_pkg::KIND_INSERT && cnt_reg == '0) begin
                    ram_we    = 1'b1;
                    ram_waddr = '0;
                    ram_wdata = s_value;
                end
            end
            ST_INS: begin
                ram_we    = 1'b1;
                ram_waddr = idx_reg + AW'(1);
                ram_wdata = entry_ge ? ram_rdata : val_reg;
                ram_raddr = idx_reg - AW'(1);
            end
            ST_INS_LAST: begin
                ram_we    = 1'b1;
                ram_waddr = '0;
            end
            ST_MIN_CAP: begin
                ram_raddr = AW'(1);
            end
            ST_MIN_SH: begin
                ram_we    = 1'b1;
                ram_waddr = idx_reg - AW'(1);
                ram_wdata = ram_rdata;
                ram_raddr = idx_reg + AW'(1);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        val_reg     <= s_value;
                        status_reg  <= slmm_pkg::STATUS_DONE;
                        removed_reg <= '0;
                        idx_reg     <= cnt_m1;
                        case (s_kind)
                            slmm_pkg::KIND_INSERT: begin
                                if (cnt_reg == CW'(DEPTH)) begin
                                    status_reg <= slmm_pkg::STATUS_FULL;
                                    state_reg  <= ST_OUT;
                                end else begin
                                    cnt_reg   <= cnt_reg + CW'(1);
                                    state_reg <= (cnt_reg == '0) ? ST_OUT : ST_INS;
                                end
                            end
                            slmm_pkg::KIND_REMOVE_MIN, slmm_pkg::KIND_REMOVE_MAX: begin
                                if (cnt_reg == '0) begin
                                    status_reg <= slmm_pkg::STATUS_EMPTY;
                                    state_reg  <= ST_OUT;
                                end else begin
                                    cnt_reg   <= cnt_dec;
                                    state_reg <= (s_kind == slmm_pkg::KIND_REMOVE_MIN)
                                                 ? ST_MIN_CAP : ST_MAX_CAP;
                                end
                            end
                            default: begin
                                state_reg <= ST_OUT;
                            end
                        endcase
                    end
                end
                ST_INS: begin
                    // walk down from the top, moving entries >= value up a slot
                    if (!entry_ge) begin
                        state_reg <= ST_OUT;
                    end else if (idx_reg == '0) begin
                        state_reg <= ST_INS_LAST;
                    end else begin
                        idx_reg <= idx_reg - AW'(1);
                    end
                end
                ST_INS_LAST: begin
                    state_reg <= ST_OUT;
                end
                ST_MIN_CAP: begin
                    removed_reg <= ram_rdata;
                    idx_reg     <= AW'(1);
                    state_reg   <= (cnt_reg == '0) ? ST_OUT : ST_MIN_SH;
                end
                ST_MIN_SH: begin
                    // cnt_reg already holds the new count, i.e. the last old index
                    if (CW'(idx_reg) == cnt_reg) begin
                        state_reg <= ST_OUT;
                    end else begin
                        idx_reg <= idx_reg + AW'(1);
                    end
                end
                ST_MAX_CAP: begin
                    removed_reg <= ram_rdata;
                    state_reg   <= ST_OUT;
                end
                ST_OUT: begin
                    if (m_ready) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CW'(DEPTH))
        else $error("entry count above depth");

    a_full_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status == slmm_pkg::STATUS_FULL) |-> (m_entry_count == CW'(DEPTH)))
        else $error("full status with list not full");

    a_empty_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status == slmm_pkg::STATUS_EMPTY)
        |-> (m_entry_count == '0 && m_removed_value == '0))
        else $error("empty status with entries or a value");

    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_kind == slmm_pkg::KIND_INSERT && cnt_reg != CW'(DEPTH))
        |=> (cnt_reg == $past(cnt_reg) + CW'(1)))
        else $error("insert did not grow the list by one");
`endif

endmodule
